[rtl/core/tst_pkg.sv]
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and codes of the TCP send sequence tracker.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int unsigned SEND_BUF_SIZE_DEF = 4096;

	// commands
	localparam logic [2:0] CMD_WRITE    = 3'd0;
	localparam logic [2:0] CMD_TRANSMIT = 3'd1;
	localparam logic [2:0] CMD_SYN      = 3'd2;
	localparam logic [2:0] CMD_FIN      = 3'd3;
	localparam logic [2:0] CMD_ACK      = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_WRITE   = 2'd1;
	localparam logic [1:0] KIND_SEGMENT = 2'd2;
	localparam logic [1:0] KIND_ACK     = 2'd3;

	// register map: the port registers are header-only and kept outside this block
	localparam logic [1:0] CFG_MSS = 2'd0;

	localparam logic [15:0] MSS_RESET = 16'd536;
	localparam logic [31:0] SIGN32    = 32'h8000_0000;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] write_len;
		logic [31:0] ack_number;
		logic [31:0] rcv_next;
		logic [15:0] rcv_window;
		logic        peer_seq_known;
	} request_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] accepted_len;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic        flag_syn;
		logic        flag_ack;
		logic        flag_fin;
		logic [15:0] seg_window;
		logic [16:0] data_offset;
		logic [15:0] data_len;
		logic        writer_wake;
	} result_t;

	typedef struct packed {
		logic [1:0]  addr;
		logic [15:0] wdata;
	} cfg_write_t;

	typedef struct packed {
		logic syn_pending;
		logic fin_pending;
	} marks_t;

endpackage

[rtl/core/tst_chan_if.sv]
// ----------------------------------------------------------------------------
// tst_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface tst_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/tcp_send_sequence_tracker.sv]
// ----------------------------------------------------------------------------
// tcp_send_sequence_tracker
// Send sequence state of one TCP connection with segment descriptor output.
// ----------------------------------------------------------------------------
// Takes one command per clock unless the result is stalled, and returns exactly
// one result per command, in order, through an input register and then a result
// register. The throughput of one command per cycle is set by the state update
// path: the sequence adders and buffer count are combinational between the state
// registers, so each command sees the state left by the one before it.
// The result register lets a new command enter while a result waits to be
// taken. Configuration writes are always accepted and must be made while no
// command is in flight; only the segment size register is stored, the port
// registers belong to the header builder downstream.
module tcp_send_sequence_tracker #(
	parameter int unsigned SEND_BUF_SIZE = tst_pkg::SEND_BUF_SIZE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tst_chan_if.sink   request,
	tst_chan_if.source result,
	tst_chan_if.sink   cfg
);
	import tst_pkg::*;

	localparam int unsigned BW = $clog2(SEND_BUF_SIZE + 1);

	request_t      req_s1;
	logic          req_valid_s1;
	result_t       res_q;
	logic          res_valid_q;
	logic          advance;

	logic [15:0]   mss_q;
	logic [31:0]   send_unacked_q;
	logic [31:0]   send_next_q;
	logic [BW-1:0] buffered_q;
	marks_t        marks_q;

	logic [31:0]   send_unacked_nx;
	logic [31:0]   send_next_nx;
	logic [BW-1:0] buffered_nx;
	marks_t        marks_nx;
	result_t       res_nx;

	assign advance       = req_valid_s1 && (!res_valid_q || result.ready);
	assign request.ready = !req_valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	tst_step #(
		.SEND_BUF_SIZE (SEND_BUF_SIZE)
	) u_step (
		.request         (req_s1),
		.mss             (mss_q),
		.send_unacked    (send_unacked_q),
		.send_next       (send_next_q),
		.buffered        (buffered_q),
		.marks           (marks_q),
		.send_unacked_nx (send_unacked_nx),
		.send_next_nx    (send_next_nx),
		.buffered_nx     (buffered_nx),
		.marks_nx        (marks_nx),
		.result          (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (request.valid && request.ready) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready)
			req_s1 <= request.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q    <= 1'b0;
			send_unacked_q <= '0;
			send_next_q    <= '0;
			buffered_q     <= '0;
			marks_q        <= '0;
		end else if (advance) begin
			res_valid_q    <= 1'b1;
			send_unacked_q <= send_unacked_nx;
			send_next_q    <= send_next_nx;
			buffered_q     <= buffered_nx;
			marks_q        <= marks_nx;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q <= MSS_RESET;
		end else if (cfg.valid && cfg.payload.addr == CFG_MSS) begin
			mss_q <= cfg.payload.wdata;
		end
	end

endmodule

[rtl/core/tst_step.sv]
// ----------------------------------------------------------------------------
// tst_step
// Next-state and result logic for one command of the send sequence tracker.
// ----------------------------------------------------------------------------
module tst_step #(
	parameter int unsigned SEND_BUF_SIZE = tst_pkg::SEND_BUF_SIZE_DEF
) (
	input  tst_pkg::request_t                        request,
	input  logic [15:0]                              mss,
	input  logic [31:0]                              send_unacked,
	input  logic [31:0]                              send_next,
	input  logic [$clog2(SEND_BUF_SIZE + 1) - 1:0]   buffered,
	input  tst_pkg::marks_t                          marks,
	output logic [31:0]                              send_unacked_nx,
	output logic [31:0]                              send_next_nx,
	output logic [$clog2(SEND_BUF_SIZE + 1) - 1:0]   buffered_nx,
	output tst_pkg::marks_t                          marks_nx,
	output tst_pkg::result_t                         result
);
	import tst_pkg::*;

	localparam int unsigned BW = $clog2(SEND_BUF_SIZE + 1);
	localparam logic [BW-1:0] BUF_SIZE_W = BW'(SEND_BUF_SIZE);

	logic [31:0] buf32;

	// write
	logic [BW-1:0] room_cnt;
	logic [15:0]   wr_len;

	// transmit
	logic          syn_eff;
	logic          fin_eff;
	logic [31:0]   in_flight;
	logic          syn_held;
	logic [31:0]   doff;
	logic          nothing_left;
	logic [16:0]   remain;
	logic [15:0]   mss_eff;
	logic          capped;
	logic [15:0]   dlen;
	logic          fsyn;
	logic          ffin;

	// ack
	logic [31:0]   su1;
	logic [31:0]   acked;
	logic [31:0]   unacked;
	logic [31:0]   cur;
	logic          no_free;
	logic [31:0]   removed;

	assign buf32 = {{(32 - BW){1'b0}}, buffered};

	assign room_cnt = BUF_SIZE_W - buffered;
	assign wr_len   = ({16'd0, request.write_len} < {{(32 - BW){1'b0}}, room_cnt})
		? request.write_len : 16'(room_cnt);

	// SYN and FIN commands raise their mark before the segment is formed
	assign syn_eff      = marks.syn_pending || (request.cmd == CMD_SYN);
	assign fin_eff      = marks.fin_pending || (request.cmd == CMD_FIN);
	assign in_flight    = send_next - send_unacked;
	assign syn_held     = syn_eff && (in_flight != 32'd0);
	assign doff         = in_flight - {31'd0, syn_held};
	assign nothing_left = doff > buf32;
	assign remain       = buf32[16:0] - doff[16:0];
	assign mss_eff      = (mss == 16'd0) ? 16'd1 : mss;
	assign capped       = remain > {1'b0, mss_eff};
	assign dlen         = capped ? mss_eff : remain[15:0];
	assign fsyn         = syn_eff && !syn_held;
	// FIN only rides on the segment that carries the last buffered byte
	assign ffin         = fin_eff && !capped;

	assign su1      = send_unacked + {31'd0, marks.syn_pending};
	assign acked    = request.ack_number - su1;
	assign unacked  = send_next - su1;
	assign cur      = ((unacked ^ SIGN32) < (acked ^ SIGN32)) ? unacked : acked;
	assign no_free  = (cur == 32'd0) || cur[31];
	assign removed  = (cur < buf32) ? cur : buf32;

	always_comb begin
		send_unacked_nx = send_unacked;
		send_next_nx    = send_next;
		buffered_nx     = buffered;
		marks_nx        = marks;
		result          = '0;
		case (request.cmd)
			CMD_WRITE: begin
				buffered_nx         = buffered + BW'(wr_len);
				result.kind         = KIND_WRITE;
				result.accepted_len = wr_len;
			end
			CMD_TRANSMIT, CMD_SYN, CMD_FIN: begin
				marks_nx.syn_pending = syn_eff;
				marks_nx.fin_pending = fin_eff;
				if (!nothing_left) begin
					send_next_nx       = send_next + {16'd0, dlen}
						+ {31'd0, fsyn} + {31'd0, ffin};
					result.kind        = KIND_SEGMENT;
					result.seg_seq     = send_next;
					result.seg_ack     = request.rcv_next;
					result.flag_syn    = fsyn;
					result.flag_ack    = request.peer_seq_known;
					result.flag_fin    = ffin;
					result.seg_window  = request.rcv_window;
					result.data_offset = doff[16:0];
					result.data_len    = dlen;
				end
			end
			CMD_ACK: begin
				// a pending SYN is consumed by any ACK
				send_unacked_nx      = su1;
				marks_nx.syn_pending = 1'b0;
				result.kind          = KIND_ACK;
				if (!no_free) begin
					send_unacked_nx = su1 + cur;
					buffered_nx     = buffered - removed[BW-1:0];
					if (cur != removed)
						marks_nx.fin_pending = 1'b0;
					result.accepted_len = (removed > 32'h0000_FFFF)
						? 16'hFFFF : removed[15:0];
					result.writer_wake  = 1'b1;
				end
			end
			default: begin
				result.kind = KIND_NONE;
			end
		endcase
	end

endmodule
